@@ design/dnd_pkg.sv @@
// shared types and constants for the dns name decompress unit
`timescale 1ns / 1ps

package dnd_pkg;

  localparam int PACKET_DEPTH_DEF   = 512;
  localparam int MAX_NAME_BYTES_DEF = 255;
  localparam int MAX_JUMPS_DEF      = 63;

  localparam int          PTR_BITS    = 14;
  localparam logic [1:0]  PTR_MARK    = 2'b11;
  localparam int          LANES       = 8;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_EXTRACT = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PTR,
    ST_NAME_RD,
    ST_EMIT,
    ST_ERR
  } back_state_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data_byte;
    logic [8:0]  name_offset;
  } cmd_t;

  typedef struct packed {
    logic [63:0] name_chunk;
    logic [3:0]  chunk_bytes;
    logic        last;
    logic        status;
    logic [8:0]  consumed_length;
    logic [7:0]  name_length;
  } res_t;

endpackage

@@ design/dnd_front.sv @@
// front end: accepts input beats, drops unused codes, queues commands
`timescale 1ns / 1ps

module dnd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    action,
  input  logic [7:0]    data_byte,
  input  logic [8:0]    name_offset,
  output logic          cmd_valid,
  output dnd_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import dnd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          known, do_push, do_pop;

  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign known     = action inside {ACT_CLEAR, ACT_APPEND, ACT_EXTRACT};
  assign do_push   = push && !full && known;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= '{action: action_t'(action), data_byte: data_byte,
                         name_offset: name_offset};
    end
  end

endmodule

@@ design/dnd_back.sv @@
// back end: packet store, name walker and chunk emitter
`timescale 1ns / 1ps

module dnd_back #(
  parameter int PACKET_DEPTH   = dnd_pkg::PACKET_DEPTH_DEF,
  parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_JUMPS      = dnd_pkg::MAX_JUMPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  dnd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output dnd_pkg::res_t res
);
  import dnd_pkg::*;

  localparam int AW  = $clog2(PACKET_DEPTH);
  localparam int LW  = $clog2(PACKET_DEPTH + 1);
  localparam int CW  = (LW > PTR_BITS) ? LW : PTR_BITS;
  localparam int LB  = $clog2(LANES);
  localparam int NW  = (MAX_NAME_BYTES + LANES - 1) / LANES;
  localparam int NWW = (NW > 1) ? $clog2(NW) : 1;
  localparam int JW  = $clog2(MAX_JUMPS + 1);

  back_state_t   state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    size_r, size_nxt;
  logic [8:0]    cons_r, cons_nxt;
  logic [JW-1:0] jumps_r, jumps_nxt;
  logic          jumped_r, jumped_nxt;
  logic [5:0]    ptr_hi_r, ptr_hi_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [NWW-1:0] widx_r, widx_nxt;

  logic [7:0]    pkt_mem [PACKET_DEPTH];
  logic [7:0]    pkt_rd_r;
  logic [AW-1:0] pkt_ra, pkt_wa;
  logic          pkt_we;
  logic [63:0]   name_mem [NW];
  logic [63:0]   name_rd_r;
  logic          name_we;

  logic [CW-1:0]       pos_inc, len_ext;
  logic [PTR_BITS-1:0] target;
  logic [3:0]          chunk_n;
  logic                chunk_last;
  logic [63:0]         chunk;

  assign pkt_wa  = AW'(len_r);
  assign pos_inc = CW'(pos_r) + CW'(1);
  assign len_ext = CW'(len_r);
  assign target  = {ptr_hi_r, pkt_rd_r};

  assign chunk_last = (rem_r <= 8'(LANES));
  assign chunk_n    = chunk_last ? rem_r[3:0] : 4'(LANES);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      chunk[j*8 +: 8] = (4'(j) < chunk_n) ? name_rd_r[j*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    cons_nxt   = cons_r;
    jumps_nxt  = jumps_r;
    jumped_nxt = jumped_r;
    ptr_hi_nxt = ptr_hi_r;
    rem_nxt    = rem_r;
    widx_nxt   = widx_r;
    cmd_pop    = 1'b0;
    pkt_we     = 1'b0;
    pkt_ra     = pos_r;
    name_we    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.action)
            ACT_CLEAR: begin
              len_nxt = '0;
            end
            ACT_APPEND: begin
              if (len_ext < CW'(PACKET_DEPTH)) begin
                pkt_we  = 1'b1;
                len_nxt = len_r + LW'(1);
              end
            end
            ACT_EXTRACT: begin
              size_nxt   = '0;
              cons_nxt   = '0;
              jumps_nxt  = '0;
              jumped_nxt = 1'b0;
              pos_nxt    = AW'(cmd.name_offset);
              pkt_ra     = AW'(cmd.name_offset);
              state_nxt  = (CW'(cmd.name_offset) >= len_ext) ? ST_ERR : ST_BYTE;
            end
            default: ;
          endcase
        end
      end
      ST_BYTE: begin
        if (pkt_rd_r[7:6] == PTR_MARK) begin
          if (pos_inc >= len_ext) begin
            state_nxt = ST_ERR;
          end else begin
            ptr_hi_nxt = pkt_rd_r[5:0];
            pkt_ra     = AW'(pos_inc);
            state_nxt  = ST_PTR;
          end
        end else if (CW'(size_r) >= CW'(MAX_NAME_BYTES) || CW'(size_r) >= len_ext) begin
          state_nxt = ST_ERR;
        end else begin
          name_we  = 1'b1;
          size_nxt = size_r + 8'd1;
          if (!jumped_r) begin
            cons_nxt = cons_r + 9'd1;
          end
          if (pkt_rd_r == 8'h00) begin
            rem_nxt   = size_r + 8'd1;
            widx_nxt  = '0;
            state_nxt = ST_NAME_RD;
          end else if (pos_inc >= len_ext) begin
            state_nxt = ST_ERR;
          end else begin
            pos_nxt = AW'(pos_inc);
            pkt_ra  = AW'(pos_inc);
          end
        end
      end
      ST_PTR: begin
        if (jumps_r >= JW'(MAX_JUMPS)) begin
          state_nxt = ST_ERR;
        end else begin
          jumps_nxt  = jumps_r + JW'(1);
          jumped_nxt = 1'b1;
          if (!jumped_r) begin
            cons_nxt = cons_r + 9'd2;
          end
          if (CW'(target) >= len_ext) begin
            state_nxt = ST_ERR;
          end else begin
            pos_nxt   = AW'(target);
            pkt_ra    = AW'(target);
            state_nxt = ST_BYTE;
          end
        end
      end
      ST_NAME_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        res.name_chunk      = chunk;
        res.chunk_bytes     = chunk_n;
        res.last            = chunk_last;
        res.status          = 1'b0;
        res.consumed_length = cons_r;
        res.name_length     = size_r;
        if (!res_full) begin
          res_push = 1'b1;
          if (chunk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt   = rem_r - 8'(LANES);
            widx_nxt  = widx_r + NWW'(1);
            state_nxt = ST_NAME_RD;
          end
        end
      end
      ST_ERR: begin
        res.last   = 1'b1;
        res.status = 1'b1;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    size_r   <= size_nxt;
    cons_r   <= cons_nxt;
    jumps_r  <= jumps_nxt;
    jumped_r <= jumped_nxt;
    ptr_hi_r <= ptr_hi_nxt;
    rem_r    <= rem_nxt;
    widx_r   <= widx_nxt;
  end

  // packet store, one write and one read port
  always_ff @(posedge clk) begin
    if (pkt_we) begin
      pkt_mem[pkt_wa] <= cmd.data_byte;
    end
    pkt_rd_r <= pkt_mem[pkt_ra];
  end

  // decoded name, byte lane writes, one word read per cycle
  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[size_r[LB +: NWW]][8*size_r[LB-1:0] +: 8] <= pkt_rd_r;
    end
    name_rd_r <= name_mem[widx_r];
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_ext <= CW'(PACKET_DEPTH))
    else $error("packet length beyond store depth");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE) && cmd_valid)
    else $error("command taken while busy");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last) |=> (state_r == ST_IDLE))
    else $error("walker still busy after final beat");

  a_error_beat_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.status) |-> res.last && (res.chunk_bytes == 4'd0) &&
      (res.name_length == 8'd0))
    else $error("error beat carries data");
`endif

endmodule

@@ design/dnd_res_q.sv @@
// result queue between the walker and the output ports
`timescale 1ns / 1ps

module dnd_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dnd_pkg::res_t din,
  output logic          full,
  output logic          empty,
  output dnd_pkg::res_t dout,
  input  logic          pop
);
  import dnd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  res_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ design/dns_name_decompress_unit.sv @@
// top level of the dns name decompress unit
//
// channel  direction  handshake       beat
// in_      input      push / full     action, data byte, name offset
// out_     output     pop / empty     one name chunk of up to eight bytes
//
// clear and append run in the idle state; bytes load one per cycle between extracts.
// an extract walks bytes (ST_BYTE), pointers (ST_PTR), chunks (ST_NAME_RD, ST_EMIT).
// the walk speed is set by the single read port of the packet store.
// rst_n is synchronous; it empties both queues and zeroes the packet length.
// a two entry queue on each side lets input and output stall independently.
`timescale 1ns / 1ps

module dns_name_decompress_unit #(
  parameter int PACKET_DEPTH   = dnd_pkg::PACKET_DEPTH_DEF,
  parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF,
  parameter int MAX_JUMPS      = dnd_pkg::MAX_JUMPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_name_offset,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_name_chunk,
  output logic [3:0]  out_chunk_bytes,
  output logic        out_last,
  output logic        out_status,
  output logic [8:0]  out_consumed_length,
  output logic [7:0]  out_name_length
);
  import dnd_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_push, res_full;
  res_t res, res_head;

  dnd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .action      (in_action),
    .data_byte   (in_data_byte),
    .name_offset (in_name_offset),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  dnd_back #(
    .PACKET_DEPTH   (PACKET_DEPTH),
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .MAX_JUMPS      (MAX_JUMPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  dnd_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .dout  (res_head),
    .pop   (out_pop)
  );

  assign out_name_chunk      = res_head.name_chunk;
  assign out_chunk_bytes     = res_head.chunk_bytes;
  assign out_last            = res_head.last;
  assign out_status          = res_head.status;
  assign out_consumed_length = res_head.consumed_length;
  assign out_name_length     = res_head.name_length;

endmodule
